/* sv/epsm_pkg.sv */
// Shared constants and types for the exact pattern stream matcher.
package epsm_pkg;

  localparam int unsigned MAX_PATTERN = 64;
  localparam int unsigned IDX_W       = $clog2(MAX_PATTERN);
  localparam int unsigned LEN_W       = $clog2(MAX_PATTERN + 1);
  localparam int unsigned SYM_W       = 8;
  localparam int unsigned THR_W       = 9;
  localparam int unsigned POS_W       = 32;
  localparam int unsigned QRY_W       = 32;
  localparam int unsigned APB_DW      = 32;
  localparam int unsigned PADDR_W     = 3;

  localparam logic [THR_W-1:0] THR_RESET = THR_W'(254);
  localparam logic [LEN_W-1:0] LEN_MAX   = LEN_W'(MAX_PATTERN);

  // Input operation codes
  localparam logic OP_PATTERN  = 1'b0;
  localparam logic OP_SEQUENCE = 1'b1;

  // Register word index (paddr bit 2 upward)
  localparam logic REG_THRESHOLD = 1'b0;

  // Control word broadcast to every cell of the chain
  typedef struct packed {
    logic             pat_wr;   // load one pattern symbol
    logic [IDX_W-1:0] wr_idx;   // cell that takes it
    logic             clear;    // pattern word: drop all partial matches
    logic             step;     // sequence word: advance the chain
    logic             restart;  // sequence word starts a new sequence
    logic [SYM_W-1:0] sym;
    logic             ok;       // symbol is not special
    logic [LEN_W-1:0] len;      // pattern length in force for this step
  } epsm_ctl_t;

  typedef struct packed {
    logic [POS_W-1:0] match_start;
    logic [QRY_W-1:0] match_query;
  } epsm_res_t;

endpackage

/* sv/epsm_if.sv */
// Valid/ready channel interfaces for input words and result words.
interface epsm_in_if;
  import epsm_pkg::*;
  logic             valid;
  logic             ready;
  logic             operation;
  logic [SYM_W-1:0] symbol;
  logic             first;
  logic [QRY_W-1:0] query_number;

  modport source (output valid, operation, symbol, first, query_number, input ready);
  modport sink   (input valid, operation, symbol, first, query_number, output ready);
endinterface

interface epsm_out_if;
  import epsm_pkg::*;
  logic             valid;
  logic             ready;
  logic [POS_W-1:0] match_start;
  logic [QRY_W-1:0] match_query;

  modport source (output valid, match_start, match_query, input ready);
  modport sink   (input valid, match_start, match_query, output ready);
endinterface

/* sv/epsm_cell.sv */
// One cell of the partial-match chain: one pattern symbol and one match bit.
module epsm_cell
  import epsm_pkg::*;
(
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic [IDX_W-1:0] idx_i,
  input  epsm_ctl_t        ctl_i,
  input  logic             prev_i,
  output logic             bit_o,
  output logic             hit_o
);

  logic [SYM_W-1:0] pat_q;
  logic             bit_q, bit_d;
  logic             active;
  logic             last;

  // Cell takes part only below the pattern length; the top cell reports
  assign active = {1'b0, idx_i} < ctl_i.len;
  assign last   = ({1'b0, idx_i} + LEN_W'(1)) == ctl_i.len;

  // Next match bit
  always_comb begin
    bit_d = bit_q;
    if (ctl_i.clear) begin
      bit_d = 1'b0;
    end else if (ctl_i.step) begin
      if (active) begin
        bit_d = prev_i && ctl_i.ok && (pat_q == ctl_i.sym);
      end else if (ctl_i.restart) begin
        bit_d = 1'b0;
      end
    end
  end

  assign hit_o = ctl_i.step && last && bit_d;
  assign bit_o = bit_q;

  // Hold the pattern symbol
  always_ff @(posedge clk_i) begin
    if (ctl_i.pat_wr && (ctl_i.wr_idx == idx_i)) begin
      pat_q <= ctl_i.sym;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bit_q <= 1'b0;
    end else begin
      bit_q <= bit_d;
    end
  end

endmodule

/* sv/epsm_obuf.sv */
// Two-entry result buffer: a head register and a skid register.
module epsm_obuf
  import epsm_pkg::*;
(
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      push_i,
  input  epsm_res_t data_i,
  output logic      full_o,
  epsm_out_if.source res_o
);

  logic      head_v_q, head_v_d;
  logic      skid_v_q, skid_v_d;
  epsm_res_t head_q, head_d;
  epsm_res_t skid_q, skid_d;
  logic      pop;

  assign pop = head_v_q && res_o.ready;

  // Advance the head from the skid or from the new word
  always_comb begin
    head_v_d = head_v_q;
    skid_v_d = skid_v_q;
    head_d   = head_q;
    skid_d   = skid_q;
    if (!head_v_q) begin
      head_v_d = push_i;
      head_d   = data_i;
    end else if (pop) begin
      if (skid_v_q) begin
        head_d   = skid_q;
        skid_v_d = push_i;
        skid_d   = data_i;
      end else begin
        head_v_d = push_i;
        head_d   = data_i;
      end
    end else if (push_i) begin
      skid_v_d = 1'b1;
      skid_d   = data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_v_q <= 1'b0;
      skid_v_q <= 1'b0;
    end else begin
      head_v_q <= head_v_d;
      skid_v_q <= skid_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    head_q <= head_d;
    skid_q <= skid_d;
  end

  assign full_o            = skid_v_q;
  assign res_o.valid       = head_v_q;
  assign res_o.match_start = head_q.match_start;
  assign res_o.match_query = head_q.match_query;

endmodule

/* sv/exact_pattern_stream_matcher.sv */
// Top level: control registers, cell chain, result buffer and register port.
//
// Pattern words load one symbol each into a chain of 64 cells; sequence words
// then stream through, one word per clock, and every cell updates its match
// bit from its left neighbor in that same cycle. A match reported by the cell
// at the pattern's end is written to a two-entry result buffer (its head, or
// its skid while the head is held) and shows on the result channel from the
// head. Input is taken every cycle as long as the buffer's skid entry is free,
// so it stalls only after two results have gone untaken. The start position is
// the position counter (saturating at its top value) minus the pattern length
// less one. Nothing is cleared after reset: the block takes words at once.
module exact_pattern_stream_matcher
  import epsm_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  epsm_in_if.sink             inp_i,
  epsm_out_if.source          res_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [APB_DW-1:0]   pwdata,
  output logic [APB_DW-1:0]   prdata,
  output logic                pready
);

  logic [THR_W-1:0] thr_q;
  logic [LEN_W-1:0] len_q, len_d;
  logic             ovf_q, ovf_d;
  logic [POS_W-1:0] pos_q, pos_d;
  logic [QRY_W-1:0] qry_q, qry_d;

  logic             acc;
  logic             acc_pat;
  logic             acc_seq;
  logic [LEN_W-1:0] len_eff;
  logic [POS_W-1:0] pos_eff;
  logic             full;
  logic             push;
  epsm_ctl_t        ctl;
  epsm_res_t        res;

  logic [MAX_PATTERN-1:0] chain;
  logic [MAX_PATTERN-1:0] hits;

  // Register port
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_THRESHOLD) ? APB_DW'(thr_q) : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q <= THR_RESET;
    end else if (psel && penable && pwrite && pready && (paddr[2] == REG_THRESHOLD)) begin
      thr_q <= pwdata[THR_W-1:0];
    end
  end

  // Input handshake
  assign inp_i.ready = !full;
  assign acc         = inp_i.valid && inp_i.ready;
  assign acc_pat     = acc && (inp_i.operation == OP_PATTERN);
  assign acc_seq     = acc && (inp_i.operation == OP_SEQUENCE);

  // Pattern length, overflow mark, query id and position
  assign len_eff = (inp_i.first && acc_pat) ? '0 : len_q;
  assign pos_eff = inp_i.first ? '0 : pos_q;

  always_comb begin
    len_d = len_q;
    ovf_d = ovf_q;
    qry_d = qry_q;
    pos_d = pos_q;
    if (acc_pat) begin
      if (inp_i.first) begin
        ovf_d = 1'b0;
        qry_d = inp_i.query_number;
      end
      if (len_eff < LEN_MAX) begin
        len_d = len_eff + LEN_W'(1);
      end else begin
        len_d = len_eff;
        ovf_d = 1'b1;
      end
    end
    if (acc_seq) begin
      pos_d = (pos_eff == '1) ? pos_eff : pos_eff + POS_W'(1);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0;
      ovf_q <= 1'b0;
      qry_q <= '0;
      pos_q <= '0;
    end else begin
      len_q <= len_d;
      ovf_q <= ovf_d;
      qry_q <= qry_d;
      pos_q <= pos_d;
    end
  end

  // Broadcast control to the chain
  always_comb begin
    ctl.pat_wr  = acc_pat && (len_eff < LEN_MAX);
    ctl.wr_idx  = len_eff[IDX_W-1:0];
    ctl.clear   = acc_pat;
    ctl.step    = acc_seq;
    ctl.restart = inp_i.first;
    ctl.sym     = inp_i.symbol;
    ctl.ok      = {1'b0, inp_i.symbol} < thr_q;
    ctl.len     = len_q;
  end

  // Chain of cells; a new sequence masks the old partial matches
  for (genvar k = 0; k < MAX_PATTERN; k++) begin : g_cell
    logic prev;
    if (k == 0) begin : g_head
      assign prev = 1'b1;
    end else begin : g_link
      assign prev = chain[k-1] && !inp_i.first;
    end
    epsm_cell u_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .idx_i  (IDX_W'(k)),
      .ctl_i  (ctl),
      .prev_i (prev),
      .bit_o  (chain[k]),
      .hit_o  (hits[k])
    );
  end

  // Form the result word
  assign push            = (|hits) && !ovf_q;
  assign res.match_start = pos_eff - POS_W'(len_q - LEN_W'(1));
  assign res.match_query = qry_q;

  epsm_obuf u_obuf (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .data_i (res),
    .full_o (full),
    .res_o  (res_o)
  );

  // Overflow is only possible with a full pattern
  a_ovf_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ovf_q |-> (len_q == LEN_MAX))
    else $error("overflow mark set below full pattern length");

  // A pattern word leaves no partial match behind
  a_pat_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    acc_pat |=> (chain == '0))
    else $error("partial matches survive a pattern word");

  // No result is pushed into a full buffer
  a_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    push |-> !full)
    else $error("result pushed while buffer full");

endmodule
